// ===== sv/nrs_pkg.sv =====
// Shared definitions for the integer nth root search unit.
// Holds default sizes, the controller state type and the command/status structs.
// No dependencies.
package nrs_pkg;

  // Default sizes of the value field and the largest root degree.
  localparam int unsigned VALUE_WIDTH_DEF = 31;
  localparam int unsigned EXP_MAX_DEF     = 63;

  // Width of the exponent port, fixed by the item format.
  localparam int unsigned EXP_PORT_WIDTH = 6;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_POWER,
    ST_DONE
  } nrs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture a new item and open the search range
    logic probe_setup;  // take the midpoint and restart the power
    logic mult;         // one more multiplication of the running power
    logic go_low;       // power fell short: raise the lower bound
    logic go_high;      // power overshot: lower the upper bound
    logic finish_hit;   // exact root found
    logic finish_miss;  // range empty, no exact root
  } nrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_ok;     // lower bound not above upper bound
    logic acc_gt;       // running power exceeds the value
    logic acc_eq;       // running power equals the value
    logic count_done;   // all multiplications of this probe are done
  } nrs_status_t;

endpackage

// ===== sv/nrs_datapath.sv =====
// Datapath of the integer nth root search unit: bounds, probe, running power.
// Depends on nrs_pkg for the command and status structs.
module nrs_datapath #(
  parameter int unsigned VALUE_WIDTH = nrs_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned EXP_MAX     = nrs_pkg::EXP_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nrs_pkg::nrs_cmd_t                  cmd,
  output nrs_pkg::nrs_status_t               status,
  input  logic [nrs_pkg::EXP_PORT_WIDTH-1:0] in_exponent,
  input  logic [VALUE_WIDTH-1:0]             in_value,
  output logic                               found,
  output logic [VALUE_WIDTH-1:0]             root
);
  import nrs_pkg::*;

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned PW = 2 * VALUE_WIDTH;
  localparam int unsigned EW = (EXP_MAX < 2) ? 1 : $clog2(EXP_MAX + 1);
  localparam logic [EXP_PORT_WIDTH-1:0] EXP_SAT = EXP_PORT_WIDTH'(EXP_MAX);

  logic [EW-1:0] exp_r;
  logic [W-1:0]  value_r;
  logic [W:0]    lo_r;
  logic [W-1:0]  hi_r;
  logic [W-1:0]  mid_r;
  logic [PW-1:0] acc_r;
  logic [EW-1:0] cnt_r;
  logic          found_r;
  logic [W-1:0]  root_r;

  logic [EW-1:0] exp_nxt;
  logic [W-1:0]  span;
  logic [W-1:0]  mid_nxt;
  logic [PW-1:0] prod;

  // Saturate the root degree to the largest supported one.
  assign exp_nxt = (in_exponent > EXP_SAT) ? EW'(EXP_MAX) : EW'(in_exponent);

  // Midpoint of the current range; valid whenever the range is not empty.
  assign span    = hi_r - lo_r[W-1:0];
  assign mid_nxt = lo_r[W-1:0] + (span >> 1);

  // The running power never exceeds the value before a multiplication,
  // so its low half carries all of it.
  assign prod = PW'(acc_r[W-1:0]) * PW'(mid_r);

  // Status towards the controller.
  assign status.range_ok   = (lo_r <= {1'b0, hi_r});
  assign status.acc_gt     = (acc_r > PW'(value_r));
  assign status.acc_eq     = (acc_r == PW'(value_r));
  assign status.count_done = (cnt_r == exp_r);

  // Search registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_r   <= exp_nxt;
      value_r <= in_value;
      lo_r    <= (W + 1)'(1);
      hi_r    <= in_value;
    end
    if (cmd.probe_setup) begin
      mid_r <= mid_nxt;
      acc_r <= PW'(1);
      cnt_r <= '0;
    end
    if (cmd.mult) begin
      acc_r <= prod;
      cnt_r <= cnt_r + EW'(1);
    end
    if (cmd.go_low) begin
      lo_r <= {1'b0, mid_r} + (W + 1)'(1);
    end
    if (cmd.go_high) begin
      hi_r <= mid_r - W'(1);
    end
  end

  // Result registers, held until the next item finishes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      root_r  <= '0;
    end else if (cmd.finish_hit) begin
      found_r <= 1'b1;
      root_r  <= mid_r;
    end else if (cmd.finish_miss) begin
      found_r <= 1'b0;
      root_r  <= '0;
    end
  end

  assign found = found_r;
  assign root  = root_r;

  // A multiplication only starts from a power that has not passed the value.
  a_mult_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mult |-> !status.acc_gt)
    else $error("multiplication started from a power above the value");

  // A fresh probe lies within the bounds it was taken from.
  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.probe_setup |=> (({1'b0, mid_r} >= $past(lo_r)) && (mid_r <= $past(hi_r))))
    else $error("probe outside the search range");

  // A hit reports the probe whose power matched.
  a_hit_root: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish_hit |=> (found_r && (root_r == $past(mid_r))))
    else $error("hit reported with wrong root");

endmodule

// ===== sv/nrs_controller.sv =====
// Controller of the integer nth root search unit: sequences probes and powers.
// Depends on nrs_pkg for the state type and the command/status structs.
module nrs_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  nrs_pkg::nrs_status_t status,
  output nrs_pkg::nrs_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import nrs_pkg::*;

  nrs_state_t state_r;
  nrs_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        state_nxt = status.range_ok ? ST_POWER : ST_DONE;
      end
      ST_POWER: begin
        if (status.acc_gt) begin
          state_nxt = ST_PROBE;
        end else if (status.count_done) begin
          state_nxt = status.acc_eq ? ST_DONE : ST_PROBE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_PROBE: begin
        if (status.range_ok) begin
          cmd.probe_setup = 1'b1;
        end else begin
          cmd.finish_miss = 1'b1;
        end
      end
      ST_POWER: begin
        if (status.acc_gt) begin
          cmd.go_high = 1'b1;
        end else if (status.count_done) begin
          if (status.acc_eq) begin
            cmd.finish_hit = 1'b1;
          end else begin
            cmd.go_low = 1'b1;
          end
        end else begin
          cmd.mult = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);
  assign done = (state_r == ST_DONE);

  // The result strobe lasts one cycle and is followed by idle.
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> (state_r == ST_IDLE))
    else $error("result strobe longer than one cycle");

  // An accepted item always starts with a probe.
  a_start_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_PROBE))
    else $error("accepted item did not start a probe");

  // At most one command at a time.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule

// ===== sv/integer_nth_root_search_unit.sv =====
// Top level of the integer nth root search unit.
// Depends on nrs_pkg, nrs_controller and nrs_datapath.
//
// Usage: raise start with in_exponent (n) and in_value (m) while busy is low;
// the item is taken at that clock edge. The unit binary-searches 1..m for an x
// with x^n == m. Each probe takes the midpoint and restarts the power, then
// multiplies the running power by the probe at most n times, stopping early
// once the power passes m; the single multiplier is the limiting unit. Only
// a probe of 1 can need more than 31 multiplications.
// busy stays high until the result has been shown.
// The result appears for exactly one cycle, marked by out_valid, with
// out_found and out_root (zero when no exact root exists). The receiver
// cannot stall the unit; the next item may be started in the cycle after
// the strobe. An exponent above EXP_MAX is saturated to EXP_MAX. A
// synchronous active-low reset returns the unit to idle with no result
// pending.
module integer_nth_root_search_unit #(
  parameter int unsigned VALUE_WIDTH = nrs_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned EXP_MAX     = nrs_pkg::EXP_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [nrs_pkg::EXP_PORT_WIDTH-1:0] in_exponent,
  input  logic [VALUE_WIDTH-1:0]             in_value,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [VALUE_WIDTH-1:0]             out_root
);
  import nrs_pkg::*;

  nrs_cmd_t    cmd;
  nrs_status_t status;

  // Sequencing of probes and multiplications.
  nrs_controller u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (out_valid)
  );

  // Bounds, probe and running power.
  nrs_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .EXP_MAX     (EXP_MAX)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .in_exponent (in_exponent),
    .in_value    (in_value),
    .found       (out_found),
    .root        (out_root)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for integer_nth_root_search_unit: directed items, then random ones.
// Each accepted item is checked on out_valid against its golden row or a binary-search model.
// Depends on nrs_pkg and the unit's RTL only.
module testbench;
  import nrs_pkg::*;

  localparam int unsigned VW = VALUE_WIDTH_DEF;
  localparam int unsigned EW = EXP_PORT_WIDTH;
  localparam logic [VW-1:0] VALUE_MAX = {VW{1'b1}};
  localparam int N_DIRECTED = 24;
  localparam int RANDOM_ITEMS = 556;
  localparam int QUIET_TAIL = 60;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int MAX_REPORTS = 40;

  // One result of the unit.
  typedef struct packed {
    logic          found;
    logic [VW-1:0] root;
  } root_result_t;

  // One row of the directed table; golden rows carry a hand-worked result.
  typedef struct packed {
    logic [EW-1:0] exponent;
    logic [VW-1:0] value;
    logic          golden;
    logic          found;
    logic [VW-1:0] root;
  } stim_row_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [EW-1:0] in_exponent;
  logic [VW-1:0] in_value;
  logic          out_valid;
  logic          out_found;
  logic [VW-1:0] out_root;

  root_result_t pending_roots[$];
  int           mismatch_count = 0;
  int           cycle_count = 0;

  stim_row_t directed_rows [N_DIRECTED] = '{
    '{6'd0,  31'd0,          1'b1, 1'b0, 31'd0},
    '{6'd63, 31'd0,          1'b1, 1'b0, 31'd0},
    '{6'd1,  31'd0,          1'b1, 1'b0, 31'd0},
    '{6'd0,  31'd1,          1'b1, 1'b1, 31'd1},
    '{6'd0,  31'd2,          1'b1, 1'b0, 31'd0},
    '{6'd0,  VALUE_MAX,      1'b1, 1'b0, 31'd0},
    '{6'd63, 31'd1,          1'b1, 1'b1, 31'd1},
    '{6'd1,  31'd1,          1'b1, 1'b1, 31'd1},
    '{6'd1,  VALUE_MAX,      1'b1, 1'b1, VALUE_MAX},
    '{6'd2,  VALUE_MAX,      1'b0, 1'b0, 31'd0},
    '{6'd63, VALUE_MAX,      1'b0, 1'b0, 31'd0},
    '{6'd30, 31'h4000_0000,  1'b1, 1'b1, 31'd2},
    '{6'd2,  31'd2147395600, 1'b1, 1'b1, 31'd46340},
    '{6'd2,  31'd2147395601, 1'b0, 1'b0, 31'd0},
    '{6'd3,  31'd2146689000, 1'b0, 1'b0, 31'd0},
    '{6'd31, 31'h4000_0000,  1'b0, 1'b0, 31'd0},
    '{6'd5,  31'd243,        1'b1, 1'b1, 31'd3},
    '{6'd2,  31'h2AAA_AAAA,  1'b0, 1'b0, 31'd0},
    '{6'd2,  31'h5555_5555,  1'b0, 1'b0, 31'd0},
    '{6'd1,  31'h2AAA_AAAA,  1'b1, 1'b1, 31'h2AAA_AAAA},
    '{6'd42, 31'h1555_5555,  1'b0, 1'b0, 31'd0},
    '{6'd21, 31'd2097152,    1'b1, 1'b1, 31'd2},
    '{6'd2,  31'd4,          1'b1, 1'b1, 31'd2},
    '{6'd2,  31'd3,          1'b0, 1'b0, 31'd0}
  };

  integer_nth_root_search_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_exponent (in_exponent),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_found   (out_found),
    .out_root    (out_root)
  );

  // Clock with a period of 10 time units.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Raises base to the power n, stopping at the first partial product above cap.
  function automatic longint unsigned capped_power(longint unsigned base, longint unsigned n,
                                                   longint unsigned cap);
    longint unsigned acc;
    acc = 1;
    for (longint unsigned k = 0; k < n; k++) begin
      acc = acc * base;
      if (acc > cap) return acc;
    end
    return acc;
  endfunction

  // Binary search of 1..value for an exact root, as the unit performs it.
  task automatic predict_root(input logic [EW-1:0] exponent, input logic [VW-1:0] value,
                              output root_result_t res);
    longint unsigned n, m, lo, hi, mid, pw;
    n = exponent;
    if (n > EXP_MAX_DEF) n = EXP_MAX_DEF;
    m = value;
    lo = 1;
    hi = m;
    res = '0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      pw = capped_power(mid, n, m);
      if (pw == m) begin
        res.found = 1'b1;
        res.root = mid[VW-1:0];
        break;
      end else if (pw > m) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
  endtask

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0d] MISMATCH: %s", cycle_count, what);
  endtask

  // Offers one item, optionally after a short idle burst, and records what it should yield.
  task automatic offer_item(input stim_row_t row, input bit may_idle);
    root_result_t due;
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      // Half the bursts fall after the unit has gone idle, the rest while it is still busy.
      if ($urandom_range(0, 1) == 1) begin
        while (busy !== 1'b0) @(posedge clk);
      end
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1'b1;
    in_exponent <= row.exponent;
    in_value <= row.value;
    do @(posedge clk); while (busy !== 1'b0);
    if (row.golden) begin
      due.found = row.found;
      due.root = row.root;
    end else begin
      predict_root(row.exponent, row.value, due);
    end
    pending_roots.push_back(due);
  endtask

  // Picks a random item: mostly exact powers and their neighbours, the rest noise.
  function automatic stim_row_t random_row();
    stim_row_t row;
    longint unsigned rt, pw;
    int unsigned kind;
    row = '0;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      row.exponent = ($urandom_range(0, 3) == 0) ? EW'($urandom_range(1, 63))
                                                 : EW'($urandom_range(1, 8));
      rt = $urandom_range(1, VALUE_MAX >> $urandom_range(0, VW - 1));
      if (rt == 0) rt = 1;
      while (capped_power(rt, row.exponent, VALUE_MAX) > VALUE_MAX) rt = rt >> 1;
      pw = capped_power(rt, row.exponent, VALUE_MAX);
      if (kind == 4) pw = pw + 1;
      else if (kind == 5) pw = pw - 1;
      row.value = pw[VW-1:0];
    end else if (kind < 8) begin
      row.exponent = EW'($urandom_range(0, 63));
      row.value = VW'($urandom) >> $urandom_range(0, VW - 1);
    end else begin
      row.exponent = EW'($urandom);
      row.value = VW'($urandom);
    end
    return row;
  endfunction

  // Result checker: every strobe is matched against the oldest outstanding item.
  always @(posedge clk) begin
    root_result_t due;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("result found=%b root=%0d with no item outstanding",
                                  out_found, out_root));
      end else begin
        due = pending_roots.pop_front();
        if (out_found !== due.found)
          report_mismatch($sformatf("found %b, expected %b", out_found, due.found));
        if (out_root !== due.root)
          report_mismatch($sformatf("root %0d, expected %0d", out_root, due.root));
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Reset, directed table, random items, then drain and verdict.
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_exponent = '0;
    in_value = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) offer_item(directed_rows[i], 1'b1);
    for (int i = 0; i < RANDOM_ITEMS; i++) offer_item(random_row(), i < RANDOM_ITEMS - QUIET_TAIL);
    start <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
